@@ hw/rtl/positional_pid_speed_controller_defines.svh @@
// assertion macros shared by the speed controller rtl
`ifndef POSITIONAL_PID_SPEED_CONTROLLER_DEFINES_SVH
`define POSITIONAL_PID_SPEED_CONTROLLER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define PPSC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define PPSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/ppsc_pkg.sv @@
// shared types, widths and register codes of the speed controller
`timescale 1ns / 1ps
`default_nettype none

package ppsc_pkg;

    localparam int SPEED_W     = 16;
    localparam int GAIN_W      = 16;
    localparam int LIMIT_W     = 15;
    localparam int ERR_W       = SPEED_W + 1;
    localparam int DIFF_W      = ERR_W + 1;
    localparam int SUM_W       = 16;
    localparam int FRAC_BITS   = 8;
    localparam int PKP_W       = GAIN_W + 1 + ERR_W;
    localparam int PKI_W       = GAIN_W + 1 + SUM_W;
    localparam int PKD_W       = GAIN_W + 1 + DIFF_W;
    localparam int ACC_W       = PKD_W + 2;
    localparam int QUO_W       = ACC_W - FRAC_BITS;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // reset values of the configuration registers
    localparam logic [GAIN_W-1:0]  KP_RESET   = 16'd25600;
    localparam logic [GAIN_W-1:0]  KI_RESET   = 16'd51;
    localparam logic [GAIN_W-1:0]  KD_RESET   = 16'd0;
    localparam logic               IEN_RESET  = 1'b1;
    localparam logic [LIMIT_W-1:0] ILIM_RESET = 15'd15000;
    localparam logic [LIMIT_W-1:0] OLIM_RESET = 15'd10000;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_KP_GAIN         = 3'd0,
        REG_KI_GAIN         = 3'd1,
        REG_KD_GAIN         = 3'd2,
        REG_INTEGRAL_ENABLE = 3'd3,
        REG_INTEGRAL_LIMIT  = 3'd4,
        REG_OUTPUT_LIMIT    = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] kd;
    } gains_t;

    typedef struct packed {
        logic               integral_enable;
        logic [LIMIT_W-1:0] integral_limit;
    } integ_cfg_t;

    typedef struct packed {
        logic signed [ERR_W-1:0]  err;
        logic signed [DIFF_W-1:0] diff;
        logic signed [SUM_W-1:0]  isum;
    } terms_t;

    typedef struct packed {
        logic signed [PKP_W-1:0] p_kp;
        logic signed [PKI_W-1:0] p_ki;
        logic signed [PKD_W-1:0] p_kd;
    } products_t;

endpackage

`default_nettype wire

@@ hw/rtl/ppsc_if.sv @@
// handshake channels of the speed controller: speed samples in, drive values out
`timescale 1ns / 1ps
`default_nettype none

interface ppsc_sample_if;
    import ppsc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [SPEED_W-1:0] target_speed;
    logic signed [SPEED_W-1:0] measured_speed;

    modport source (output valid, output target_speed, output measured_speed, input ready);
    modport sink   (input valid, input target_speed, input measured_speed, output ready);
endinterface

interface ppsc_drive_if;
    import ppsc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [SPEED_W-1:0] drive_value;

    modport source (output valid, output drive_value, input ready);
    modport sink   (input valid, input drive_value, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ppsc_front.sv @@
// error, derivative difference and clamped integrator, first pipeline stage
`timescale 1ns / 1ps
`default_nettype none

`include "positional_pid_speed_controller_defines.svh"

module ppsc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  ppsc_pkg::integ_cfg_t icfg,
    ppsc_sample_if.sink         sample,
    output logic                terms_valid,
    input  logic                terms_ready,
    output ppsc_pkg::terms_t    terms
);
    import ppsc_pkg::*;

    logic                      valid_reg;
    logic                      valid_next;
    logic signed [ERR_W-1:0]   last_error_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic signed [SUM_W-1:0]   sum_next;
    terms_t                    terms_reg;
    logic                      fire;
    logic signed [ERR_W-1:0]   err;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [DIFF_W-1:0]  sum_wide;
    logic signed [DIFF_W-1:0]  lim_wide;
    logic signed [DIFF_W-1:0]  neg_lim;
    logic signed [SUM_W-1:0]   sum_clamped;

    // accept a beat when the stage is empty or drains this cycle
    assign sample.ready = !valid_reg || terms_ready;
    assign fire         = sample.valid && sample.ready;

    // error and its change since the last sample
    assign err  = {sample.target_speed[SPEED_W-1], sample.target_speed}
                - {sample.measured_speed[SPEED_W-1], sample.measured_speed};
    assign diff = {err[ERR_W-1], err} - {last_error_reg[ERR_W-1], last_error_reg};

    // integrator add and symmetric clamp
    assign sum_wide = {{(DIFF_W-SUM_W){sum_reg[SUM_W-1]}}, sum_reg}
                    + {err[ERR_W-1], err};
    assign lim_wide = {{(DIFF_W-LIMIT_W){1'b0}}, icfg.integral_limit};
    assign neg_lim  = -lim_wide;

    always_comb
    begin
        if (sum_wide > lim_wide)
        begin
            sum_clamped = lim_wide[SUM_W-1:0];
        end
        else if (sum_wide < neg_lim)
        begin
            sum_clamped = neg_lim[SUM_W-1:0];
        end
        else
        begin
            sum_clamped = sum_wide[SUM_W-1:0];
        end
    end

    // next values of stage valid and integrator
    always_comb
    begin
        valid_next = valid_reg;
        if (fire)
        begin
            valid_next = 1'b1;
        end
        else if (terms_ready)
        begin
            valid_next = 1'b0;
        end
        sum_next = sum_reg;
        if (fire && icfg.integral_enable)
        begin
            sum_next = sum_clamped;
        end
    end

    // controller state and stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= 1'b0;
            last_error_reg <= '0;
            sum_reg        <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            sum_reg   <= sum_next;
            if (fire)
            begin
                last_error_reg <= err;
            end
        end
    end

    // stage payload, integral operand zero while integration is off
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            terms_reg.err  <= err;
            terms_reg.diff <= diff;
            terms_reg.isum <= icfg.integral_enable ? sum_clamped : '0;
        end
    end

    assign terms_valid = valid_reg;
    assign terms       = terms_reg;

    // integrator stays inside the limit and holds while disabled
    `PPSC_ASSERT_NEXT(a_sum_in_limit, fire && icfg.integral_enable,
        (sum_reg <= $signed({1'b0, $past(icfg.integral_limit)}))
        && (sum_reg >= -$signed({1'b0, $past(icfg.integral_limit)})),
        "integrator outside its limit")
    `PPSC_ASSERT_NEXT(a_sum_held, fire && !icfg.integral_enable,
        sum_reg == $past(sum_reg), "integrator moved while disabled")
    `PPSC_ASSERT_NEXT(a_integral_zero, fire && !icfg.integral_enable,
        terms_reg.isum == '0, "integral operand not zero while disabled")

endmodule

`default_nettype wire

@@ hw/rtl/ppsc_mult.sv @@
// three gain multiplies, second pipeline stage
`timescale 1ns / 1ps
`default_nettype none

module ppsc_mult (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ppsc_pkg::gains_t     gains,
    input  logic                 terms_valid,
    output logic                 terms_ready,
    input  ppsc_pkg::terms_t     terms,
    output logic                 prod_valid,
    input  logic                 prod_ready,
    output ppsc_pkg::products_t  products
);
    import ppsc_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    products_t prod_reg;
    logic      fire;

    // stage moves when empty or draining
    assign terms_ready = !valid_reg || prod_ready;
    assign fire        = terms_valid && terms_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (fire)
        begin
            valid_next = 1'b1;
        end
        else if (prod_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // unsigned q8.8 gains times signed terms
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            prod_reg.p_kp <= $signed({1'b0, gains.kp}) * terms.err;
            prod_reg.p_ki <= $signed({1'b0, gains.ki}) * terms.isum;
            prod_reg.p_kd <= $signed({1'b0, gains.kd}) * terms.diff;
        end
    end

    assign prod_valid = valid_reg;
    assign products   = prod_reg;

endmodule

`default_nettype wire

@@ hw/rtl/ppsc_sat.sv @@
// sum of products, scale toward zero and output saturation, result register
`timescale 1ns / 1ps
`default_nettype none

`include "positional_pid_speed_controller_defines.svh"

module ppsc_sat (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [ppsc_pkg::LIMIT_W-1:0] output_limit,
    input  logic                        prod_valid,
    output logic                        prod_ready,
    input  ppsc_pkg::products_t         products,
    ppsc_drive_if.source                drive
);
    import ppsc_pkg::*;

    logic                      valid_reg;
    logic                      valid_next;
    logic signed [SPEED_W-1:0] drive_reg;
    logic signed [SPEED_W-1:0] drive_next;
    logic                      load;
    logic signed [ACC_W-1:0]   acc;
    logic signed [ACC_W-1:0]   biased;
    logic signed [QUO_W-1:0]   quo;
    logic signed [QUO_W-1:0]   lim_wide;
    logic signed [QUO_W-1:0]   neg_lim;

    // result register takes a beat when empty or when the sink takes one
    assign prod_ready = !valid_reg || drive.ready;
    assign load       = prod_valid && prod_ready;

    // sum of the three terms
    assign acc = {{(ACC_W-PKP_W){products.p_kp[PKP_W-1]}}, products.p_kp}
               + {{(ACC_W-PKI_W){products.p_ki[PKI_W-1]}}, products.p_ki}
               + {{(ACC_W-PKD_W){products.p_kd[PKD_W-1]}}, products.p_kd};

    // divide by 256 truncating toward zero: bias negatives before the shift
    assign biased = acc + {{(ACC_W-FRAC_BITS){1'b0}}, {FRAC_BITS{acc[ACC_W-1]}}};
    assign quo    = biased[ACC_W-1:FRAC_BITS];

    // symmetric output saturation
    assign lim_wide = {{(QUO_W-LIMIT_W){1'b0}}, output_limit};
    assign neg_lim  = -lim_wide;

    always_comb
    begin
        if (quo > lim_wide)
        begin
            drive_next = lim_wide[SPEED_W-1:0];
        end
        else if (quo < neg_lim)
        begin
            drive_next = neg_lim[SPEED_W-1:0];
        end
        else
        begin
            drive_next = quo[SPEED_W-1:0];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (drive.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            drive_reg <= drive_next;
        end
    end

    assign drive.valid       = valid_reg;
    assign drive.drive_value = drive_reg;

    // a loaded result never exceeds the output limit
    `PPSC_ASSERT_NEXT(a_drive_in_limit, load,
        (drive_reg <= $signed({1'b0, $past(output_limit)}))
        && (drive_reg >= -$signed({1'b0, $past(output_limit)})),
        "drive value outside the output limit")

endmodule

`default_nettype wire

@@ hw/rtl/positional_pid_speed_controller.sv @@
// top level of the positional pid speed controller with clamped integral
//
//   channel   dir  payload                          beat taken when
//   sample    in   target_speed, measured_speed     sample.valid && sample.ready
//   drive     out  drive_value                      drive.valid && drive.ready
//   cfg       in   cfg_index, cfg_data              cfg_wr_en
//
// three register stages: error and integrator, gain multiplies, sum/scale/saturate
// one sample per cycle while drive.ready is high; the result register raises drive.valid
// the integrator and last error update at the sample beat, so back-to-back beats chain
// sample.ready drops in the same cycle as drive.ready once all three stages hold a beat
// reset clears gains and limits to their defaults and the integrator and last error to zero
`timescale 1ns / 1ps
`default_nettype none

module positional_pid_speed_controller (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [ppsc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ppsc_pkg::CFG_DATA_W-1:0]  cfg_data,
    ppsc_sample_if.sink                     sample,
    ppsc_drive_if.source                    drive
);
    import ppsc_pkg::*;

    logic [GAIN_W-1:0]  kp_reg;
    logic [GAIN_W-1:0]  ki_reg;
    logic [GAIN_W-1:0]  kd_reg;
    logic               ien_reg;
    logic [LIMIT_W-1:0] ilim_reg;
    logic [LIMIT_W-1:0] olim_reg;

    gains_t     gains;
    integ_cfg_t icfg;
    terms_t     terms;
    logic       terms_valid;
    logic       terms_ready;
    products_t  products;
    logic       prod_valid;
    logic       prod_ready;

    // configuration registers, out-of-range indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg   <= KP_RESET;
            ki_reg   <= KI_RESET;
            kd_reg   <= KD_RESET;
            ien_reg  <= IEN_RESET;
            ilim_reg <= ILIM_RESET;
            olim_reg <= OLIM_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_KP_GAIN:
                begin
                    kp_reg <= cfg_data[GAIN_W-1:0];
                end
                REG_KI_GAIN:
                begin
                    ki_reg <= cfg_data[GAIN_W-1:0];
                end
                REG_KD_GAIN:
                begin
                    kd_reg <= cfg_data[GAIN_W-1:0];
                end
                REG_INTEGRAL_ENABLE:
                begin
                    ien_reg <= cfg_data[0];
                end
                REG_INTEGRAL_LIMIT:
                begin
                    ilim_reg <= cfg_data[LIMIT_W-1:0];
                end
                REG_OUTPUT_LIMIT:
                begin
                    olim_reg <= cfg_data[LIMIT_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    assign gains.kp              = kp_reg;
    assign gains.ki              = ki_reg;
    assign gains.kd              = kd_reg;
    assign icfg.integral_enable  = ien_reg;
    assign icfg.integral_limit   = ilim_reg;

    // error and integrator stage
    ppsc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .icfg        (icfg),
        .sample      (sample),
        .terms_valid (terms_valid),
        .terms_ready (terms_ready),
        .terms       (terms)
    );

    // gain multiply stage
    ppsc_mult u_mult (
        .clk         (clk),
        .rst_n       (rst_n),
        .gains       (gains),
        .terms_valid (terms_valid),
        .terms_ready (terms_ready),
        .terms       (terms),
        .prod_valid  (prod_valid),
        .prod_ready  (prod_ready),
        .products    (products)
    );

    // sum, scale and saturate into the result register
    ppsc_sat u_sat (
        .clk          (clk),
        .rst_n        (rst_n),
        .output_limit (olim_reg),
        .prod_valid   (prod_valid),
        .prod_ready   (prod_ready),
        .products     (products),
        .drive        (drive)
    );

endmodule

`default_nettype wire
